/* rtl/kwt_pkg.sv */
// ----------------------------------------------------------------------------
// kwt_pkg: shared types and constants of the keyed watchdog timer
// Register map, access keys, field positions and operation codes.
// ----------------------------------------------------------------------------
package kwt_pkg;

  // Bus and counter widths
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned COUNT_W    = 24;
  localparam int unsigned PRESCALE_W = 12;
  localparam int unsigned KEY_W      = 12;
  localparam int unsigned UPPER_W    = 5;
  localparam int unsigned ENABLE_W   = 3;
  localparam int unsigned PSEL_W     = 2;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned OFFSET_W   = 2;

  // Default parameter values
  localparam int unsigned FIXED_LOW_BITS_DEF     = 12;
  localparam int unsigned RESTART_VALUE_BITS_DEF = 12;

  // Access keys and their positions
  localparam logic [KEY_W-1:0]  MODE_KEY        = 12'hABC;
  localparam int unsigned       MODE_KEY_LSB    = 12;
  localparam logic [KEY_W-1:0]  CONTROL_KEY     = 12'h248;
  localparam int unsigned       CONTROL_KEY_LSB = 14;
  localparam logic [DATA_W-1:0] RESTART_KEY     = 32'h0000_1999;

  // Field positions
  localparam int unsigned MODE_UPPER_LSB = 4;
  localparam int unsigned CTRL_RV_LSB    = 2;
  localparam int unsigned CTRL_RV_W      = 12;

  // Enable bits of the mode register
  localparam int unsigned EN_WDOG  = 0;
  localparam int unsigned EN_RESET = 1;
  localparam int unsigned EN_IRQ   = 2;

  // Prescaler: divide by PRESCALE_BASE << (PRESCALE_STEP * select)
  localparam int unsigned PRESCALE_BASE = 8;
  localparam int unsigned PRESCALE_STEP = 3;
  localparam int unsigned DIV_W         = PRESCALE_W + 1;
  localparam int unsigned SHAMT_W       = 4;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [OFFSET_W-1:0] {
    REG_MODE    = 2'd0,
    REG_CONTROL = 2'd1,
    REG_RESTART = 2'd2,
    REG_STATUS  = 2'd3
  } reg_offset_e;

endpackage

/* rtl/kwt_if.sv */
// ----------------------------------------------------------------------------
// kwt_if: handshake channels of the keyed watchdog timer
// Request channel (tick or bus access) and result channel, valid/ready.
// ----------------------------------------------------------------------------
interface kwt_req_if
  import kwt_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [OFFSET_W-1:0] reg_offset;
  logic [DATA_W-1:0]   write_data;

  modport source (output valid, operation, reg_offset, write_data, input ready);
  modport sink   (input valid, operation, reg_offset, write_data, output ready);
endinterface

interface kwt_rsp_if
  import kwt_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  read_data;
  logic               reset_out;
  logic               irq_out;
  logic [COUNT_W-1:0] counter_now;

  modport source (output valid, read_data, reset_out, irq_out, counter_now, input ready);
  modport sink   (input valid, read_data, reset_out, irq_out, counter_now, output ready);
endinterface

/* rtl/keyed_watchdog_timer.sv */
// ----------------------------------------------------------------------------
// keyed_watchdog_timer: keyed watchdog with prescaled 24-bit down counter
// Ticks and keyed register accesses in, one status word out per request.
// ----------------------------------------------------------------------------
// Every accepted request (a clock tick, a register write or a register read)
// produces exactly one response word carrying the read data, the reset and
// interrupt request levels and the down counter after that request. The
// register state is updated at the edge that accepts the request, and the
// response is captured in a single output register at the same edge, so a
// new request is accepted every cycle: in_i.ready is low only while a
// response sits in the output register and the consumer holds out_o.ready
// low. Mode and control writes need their access keys in the same word;
// restart reloads only on the exact restart key. There is no clearing pass
// after reset.
// ----------------------------------------------------------------------------
module keyed_watchdog_timer
  import kwt_pkg::*;
#(
  parameter int unsigned FIXED_LOW_BITS     = FIXED_LOW_BITS_DEF,
  parameter int unsigned RESTART_VALUE_BITS = RESTART_VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kwt_req_if.sink   in_i,
  kwt_rsp_if.source out_o
);

  localparam int unsigned RELOAD_W = 32;

  // Architectural state
  logic [ENABLE_W-1:0]           enable_q, enable_d;
  logic [UPPER_W-1:0]            upper_q, upper_d;
  logic [RESTART_VALUE_BITS-1:0] rv_q, rv_d;
  logic [PSEL_W-1:0]             psel_q, psel_d;
  logic [PRESCALE_W-1:0]         pcount_q, pcount_d;
  logic [COUNT_W-1:0]            count_q, count_d;
  logic                          expired_q, expired_d;

  // Output register
  logic                          out_valid_q;
  logic [DATA_W-1:0]             rdata_q, rdata_d;
  logic                          reset_out_q, irq_out_q;
  logic [COUNT_W-1:0]            count_out_q;

  logic                          in_acc;
  logic [PRESCALE_W-1:0]         pcount_inc;
  logic [SHAMT_W-1:0]            div_shamt;
  logic [DIV_W-1:0]              divisor;
  logic [RELOAD_W-1:0]           reload_full;

  // Accept a new request whenever the output register is empty or drains now
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  // Prescaler divisor: 8, 64, 512 or 4096
  assign div_shamt  = SHAMT_W'(psel_q) * SHAMT_W'(PRESCALE_STEP);
  assign divisor    = DIV_W'(PRESCALE_BASE) << div_shamt;
  assign pcount_inc = pcount_q + PRESCALE_W'(1);

  // Reload value: restart value above FIXED_LOW_BITS ones
  assign reload_full = (RELOAD_W'(rv_q) << FIXED_LOW_BITS)
                     | ((RELOAD_W'(1) << FIXED_LOW_BITS) - RELOAD_W'(1));

  always_comb begin
    enable_d  = enable_q;
    upper_d   = upper_q;
    rv_d      = rv_q;
    psel_d    = psel_q;
    pcount_d  = pcount_q;
    count_d   = count_q;
    expired_d = expired_q;
    rdata_d   = '0;

    case (in_i.operation)
      OP_TICK: begin
        // Hold everything while the watchdog is disabled
        if (enable_q[EN_WDOG]) begin
          if (pcount_inc != '0 && DIV_W'(pcount_inc) < divisor) begin
            pcount_d = pcount_inc;
          end else begin
            pcount_d = '0;
            if (count_q != '0) begin
              count_d = count_q - COUNT_W'(1);
            end
            // Latch expiry when the counter sits at zero after this tick
            if (count_q == '0 || count_q == COUNT_W'(1)) begin
              expired_d = 1'b1;
            end
          end
        end
      end
      OP_WRITE: begin
        case (in_i.reg_offset)
          REG_MODE: begin
            if (in_i.write_data[MODE_KEY_LSB +: KEY_W] == MODE_KEY) begin
              upper_d  = in_i.write_data[MODE_UPPER_LSB +: UPPER_W];
              enable_d = in_i.write_data[ENABLE_W-1:0];
            end
          end
          REG_CONTROL: begin
            if (in_i.write_data[CONTROL_KEY_LSB +: KEY_W] == CONTROL_KEY) begin
              rv_d   = RESTART_VALUE_BITS'(
                         DATA_W'(in_i.write_data[CTRL_RV_LSB +: CTRL_RV_W]));
              psel_d = in_i.write_data[PSEL_W-1:0];
            end
          end
          REG_RESTART: begin
            if (in_i.write_data == RESTART_KEY) begin
              count_d   = reload_full[COUNT_W-1:0];
              pcount_d  = '0;
              expired_d = 1'b0;
            end
          end
          default: begin
            // Status register: drop the write
          end
        endcase
      end
      OP_READ: begin
        case (in_i.reg_offset)
          REG_MODE: begin
            rdata_d = (DATA_W'(upper_q) << MODE_UPPER_LSB) | DATA_W'(enable_q);
          end
          REG_CONTROL: begin
            rdata_d = (DATA_W'(rv_q) << CTRL_RV_LSB) | DATA_W'(psel_q);
          end
          default: begin
            rdata_d = '0;
          end
        endcase
      end
      default: begin
        // Unused operation: change nothing, report current levels
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= '0;
      upper_q     <= '0;
      rv_q        <= '0;
      psel_q      <= '0;
      pcount_q    <= '0;
      count_q     <= '1;
      expired_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        enable_q  <= enable_d;
        upper_q   <= upper_d;
        rv_q      <= rv_d;
        psel_q    <= psel_d;
        pcount_q  <= pcount_d;
        count_q   <= count_d;
        expired_q <= expired_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Response payload: capture on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rdata_q     <= rdata_d;
      reset_out_q <= expired_d && enable_d[EN_WDOG] && enable_d[EN_RESET];
      irq_out_q   <= expired_d && enable_d[EN_WDOG] && enable_d[EN_IRQ];
      count_out_q <= count_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_data   = rdata_q;
  assign out_o.reset_out   = reset_out_q;
  assign out_o.irq_out     = irq_out_q;
  assign out_o.counter_now = count_out_q;

`ifndef NO_ASSERTIONS
  // A zero counter is only reached by counting down, which latches expiry
  a_zero_means_expired: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> expired_q
  ) else $error("counter at zero without expired flag");

  // Expiry is cleared only together with a reload
  a_expired_means_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    expired_q |-> (count_q == '0)
  ) else $error("expired flag set with nonzero counter");

  // Ticks leave the counter alone while the watchdog is disabled
  a_disabled_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.operation == OP_TICK && !enable_q[EN_WDOG])
      |=> ($stable(count_q) && $stable(pcount_q))
  ) else $error("disabled watchdog moved its counter");
`endif

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the keyed watchdog timer
// Drives ticks and keyed register accesses through the request channel and
// checks every status word against a cycle-free model of the registers,
// the prescaler and the down counter, under several handshake mixes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kwt_pkg::*;

  // Block parameters; the model below follows the same values
  localparam int unsigned LOW_BITS    = FIXED_LOW_BITS_DEF;
  localparam int unsigned RV_BITS     = RESTART_VALUE_BITS_DEF;
  // The operation code that the block leaves unused
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // Longest full prescaler run, and the short run for the slowest division
  localparam int unsigned PRESCALE_RUN_MAX = 520;
  localparam int unsigned SLOW_RUN         = 40;
  // Handshake watchdog and receiver hold-off lengths, in cycles
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned HOLD_OFF     = 300;
  localparam int unsigned RANDOM_ITEMS = 430;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic               reset_out;
    logic               irq_out;
    logic [COUNT_W-1:0] counter_now;
  } status_word_t;

  logic clk;
  logic rst_n;

  kwt_req_if req_if ();
  kwt_rsp_if rsp_if ();

  keyed_watchdog_timer #(
    .FIXED_LOW_BITS     (LOW_BITS),
    .RESTART_VALUE_BITS (RV_BITS)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // Watchdog model state
  logic [ENABLE_W-1:0]   wd_enables;
  logic [UPPER_W-1:0]    wd_upper;
  logic [CTRL_RV_W-1:0]  wd_restart_val;
  logic [PSEL_W-1:0]     wd_psel;
  logic [PRESCALE_W-1:0] wd_prescale;
  logic [COUNT_W-1:0]    wd_counter;
  logic                  wd_expired;

  // Status words still owed by the block, oldest first
  status_word_t due_words[$];

  // Handshake shaping, set by the tests
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_cycles;

  // Bookkeeping
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned ticks_sent;
  int unsigned writes_sent;
  int unsigned reads_sent;
  int unsigned unused_sent;
  int unsigned words_checked;
  int unsigned alarms_seen;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model: reset and one step per accepted request word
  // --------------------------------------------------------------------------
  task automatic reset_watchdog_model();
    wd_enables     = '0;
    wd_upper       = '0;
    wd_restart_val = '0;
    wd_psel        = '0;
    wd_prescale    = '0;
    wd_counter     = '1;
    wd_expired     = 1'b0;
  endtask

  function automatic status_word_t advance_watchdog(input logic [OP_W-1:0]     op,
                                                    input logic [OFFSET_W-1:0] off,
                                                    input logic [DATA_W-1:0]   data);
    status_word_t w;
    logic [63:0]  reload;
    int unsigned  divisor;
    w = '0;
    case (op)
      OP_TICK: begin
        // A disabled watchdog freezes both the prescaler and the counter
        if (wd_enables[EN_WDOG]) begin
          divisor     = PRESCALE_BASE << (PRESCALE_STEP * wd_psel);
          wd_prescale = wd_prescale + 1'b1;
          // Count on the prescaler wrapping or reaching the divisor
          if (wd_prescale == '0 || wd_prescale >= divisor) begin
            wd_prescale = '0;
            if (wd_counter != '0) wd_counter = wd_counter - 1'b1;
            // Latch expiry; the counter sits at zero from here on
            if (wd_counter == '0) wd_expired = 1'b1;
          end
        end
      end
      OP_WRITE: begin
        case (off)
          REG_MODE: begin
            if (data[MODE_KEY_LSB +: KEY_W] == MODE_KEY) begin
              wd_upper   = data[MODE_UPPER_LSB +: UPPER_W];
              wd_enables = data[ENABLE_W-1:0];
            end
          end
          REG_CONTROL: begin
            if (data[CONTROL_KEY_LSB +: KEY_W] == CONTROL_KEY) begin
              wd_restart_val = data[CTRL_RV_LSB +: CTRL_RV_W] &
                               CTRL_RV_W'((64'd1 << RV_BITS) - 1);
              wd_psel        = data[PSEL_W-1:0];
            end
          end
          REG_RESTART: begin
            // Reload only on the exact key word
            if (data == RESTART_KEY) begin
              reload      = (64'(wd_restart_val) << LOW_BITS) | ((64'd1 << LOW_BITS) - 1);
              wd_counter  = reload[COUNT_W-1:0];
              wd_prescale = '0;
              wd_expired  = 1'b0;
            end
          end
          default: ;
        endcase
      end
      OP_READ: begin
        case (off)
          REG_MODE:    w.read_data = (DATA_W'(wd_upper) << MODE_UPPER_LSB) |
                                     DATA_W'(wd_enables);
          REG_CONTROL: w.read_data = (DATA_W'(wd_restart_val) << CTRL_RV_LSB) |
                                     DATA_W'(wd_psel);
          default:     w.read_data = '0;
        endcase
      end
      default: ;
    endcase
    w.reset_out   = wd_expired & wd_enables[EN_WDOG] & wd_enables[EN_RESET];
    w.irq_out     = wd_expired & wd_enables[EN_WDOG] & wd_enables[EN_IRQ];
    w.counter_now = wd_counter;
    return w;
  endfunction

  // Keyed words for the mode and control registers
  function automatic logic [DATA_W-1:0] mode_word(input logic [UPPER_W-1:0]  upper,
                                                  input logic [ENABLE_W-1:0] en);
    return (DATA_W'(MODE_KEY) << MODE_KEY_LSB) | (DATA_W'(upper) << MODE_UPPER_LSB) |
           DATA_W'(en);
  endfunction

  function automatic logic [DATA_W-1:0] ctrl_word(input logic [CTRL_RV_W-1:0] rv,
                                                  input logic [PSEL_W-1:0]    psel);
    return (DATA_W'(CONTROL_KEY) << CONTROL_KEY_LSB) | (DATA_W'(rv) << CTRL_RV_LSB) |
           DATA_W'(psel);
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offer one request word at the falling edge, hold it until the
  // rising edge that takes it, then log the status word it must produce
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [OP_W-1:0]     op,
                           input logic [OFFSET_W-1:0] off,
                           input logic [DATA_W-1:0]   data);
    @(negedge clk);
    // Idle cycle by cycle so that gaps land on every phase of the handshake
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid      = 1'b1;
    req_if.operation  = op;
    req_if.reg_offset = off;
    req_if.write_data = data;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    due_words.push_back(advance_watchdog(op, off, data));
    words_sent++;
    case (op)
      OP_TICK:  ticks_sent++;
      OP_WRITE: writes_sent++;
      OP_READ:  reads_sent++;
      default:  unused_sent++;
    endcase
  endtask

  // Drop valid and hold the sender until every owed status word has come
  task automatic wait_for_results();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (due_words.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: a long hold-off when one is requested, else random stalls
  // --------------------------------------------------------------------------
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        rsp_if.ready = 1'b0;
        hold_cycles--;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each status word with the oldest one owed
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    status_word_t want;
    if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (due_words.size() == 0) begin
        $display("%0t ns: status word with none owed, expected nothing, got %h %b %b %h",
                 $time, rsp_if.read_data, rsp_if.reset_out, rsp_if.irq_out,
                 rsp_if.counter_now);
        mismatches++;
      end else begin
        want = due_words.pop_front();
        check_field("read_data", want.read_data, rsp_if.read_data);
        check_field("reset_out", DATA_W'(want.reset_out), DATA_W'(rsp_if.reset_out));
        check_field("irq_out", DATA_W'(want.irq_out), DATA_W'(rsp_if.irq_out));
        check_field("counter_now", DATA_W'(want.counter_now), DATA_W'(rsp_if.counter_now));
        words_checked++;
        if (want.reset_out || want.irq_out) alarms_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Handshake watchdog: end the run if work is pending and nothing moves
  // --------------------------------------------------------------------------
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
          (req_if.valid !== 1'b1 && due_words.size() == 0)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Read every register out of reset and tick while the watchdog is off
  task automatic test_reset_values();
    send_word(OP_READ, REG_MODE, '0);
    send_word(OP_READ, REG_CONTROL, '0);
    send_word(OP_READ, REG_RESTART, '0);
    send_word(OP_READ, REG_STATUS, '0);
    send_word(OP_TICK, REG_MODE, '1);
  endtask

  // Drop writes with a wrong key, take keyed ones, read back without keys
  task automatic test_key_checks();
    send_word(OP_WRITE, REG_MODE, mode_word('1, '1) ^ (DATA_W'(1) << MODE_KEY_LSB));
    send_word(OP_READ, REG_MODE, '0);
    // Key in place with every other bit set: stray bits must not stick
    send_word(OP_WRITE, REG_MODE, 32'hFFAB_CFFF);
    send_word(OP_READ, REG_MODE, '0);
    send_word(OP_WRITE, REG_CONTROL, ctrl_word('1, '1) ^ (DATA_W'(1) << (CONTROL_KEY_LSB + 11)));
    send_word(OP_WRITE, REG_CONTROL, 32'hFC92_3FFF);
    send_word(OP_READ, REG_CONTROL, '0);
    send_word(OP_WRITE, REG_STATUS, '1);
    send_word(OP_READ, REG_STATUS, '0);
  endtask

  // Reload only on the exact restart word; restart reads as zero
  task automatic test_restart();
    send_word(OP_TICK, REG_MODE, '0);
    send_word(OP_WRITE, REG_RESTART, RESTART_KEY - 1);
    send_word(OP_WRITE, REG_RESTART, RESTART_KEY | (DATA_W'(1) << 16));
    send_word(OP_WRITE, REG_RESTART, RESTART_KEY);
    send_word(OP_READ, REG_RESTART, '0);
  endtask

  // The unused operation changes nothing and reads zero
  task automatic test_unused_op();
    send_word(OP_UNUSED, REG_MODE, '1);
    send_word(OP_UNUSED, REG_CONTROL, '0);
    send_word(OP_READ, REG_MODE, '0);
  endtask

  // Walk each prescaler division past one full count; the slowest one only
  // gets a short run, in which it must hold the counter
  task automatic test_prescaler();
    int unsigned divisor;
    int unsigned ticks;
    for (int psel = 0; psel < 4; psel++) begin
      divisor = PRESCALE_BASE << (PRESCALE_STEP * psel);
      ticks   = (divisor + 2 <= PRESCALE_RUN_MAX) ? divisor + 2 : SLOW_RUN;
      send_word(OP_WRITE, REG_MODE, mode_word(UPPER_W'($urandom), 3'b001));
      send_word(OP_WRITE, REG_CONTROL, ctrl_word(CTRL_RV_W'($urandom_range(15)), PSEL_W'(psel)));
      send_word(OP_WRITE, REG_RESTART, RESTART_KEY);
      repeat (ticks) send_word(OP_TICK, REG_STATUS, '0);
    end
    wait_for_results();
  endtask

  // One random request word, mostly keyed writes and ticks with some noise
  task automatic send_random_word();
    logic [OP_W-1:0]     op;
    logic [OFFSET_W-1:0] off;
    logic [DATA_W-1:0]   data;
    int unsigned         pick;
    int unsigned         form;
    pick = $urandom_range(99);
    off  = OFFSET_W'($urandom_range(3));
    data = $urandom;
    form = $urandom_range(9);
    if (pick < 55) begin
      op = OP_TICK;
    end else if (pick < 82) begin
      op = OP_WRITE;
      case (off)
        REG_MODE: begin
          data[MODE_KEY_LSB +: KEY_W] = MODE_KEY;
          if ($urandom_range(3) != 0) data[EN_WDOG] = 1'b1;
          // Break the key in a few words, or leave the word as noise
          if (form == 7) data[MODE_KEY_LSB + $urandom_range(KEY_W-1)] ^= 1'b1;
          if (form >= 8) data = $urandom;
        end
        REG_CONTROL: begin
          data[CONTROL_KEY_LSB +: KEY_W] = CONTROL_KEY;
          if (form == 7) data[CONTROL_KEY_LSB + $urandom_range(KEY_W-1)] ^= 1'b1;
          if (form >= 8) data = $urandom;
        end
        REG_RESTART: begin
          if (form < 6) data = RESTART_KEY;
          else if (form < 8) data = RESTART_KEY ^ (DATA_W'(1) << $urandom_range(DATA_W-1));
        end
        default: ;
      endcase
    end else if (pick < 97) begin
      op = OP_READ;
    end else begin
      op = OP_UNUSED;
    end
    send_word(op, off, data);
  endtask

  // A stretch of random words under one handshake mix; optionally start a
  // long receiver hold-off or pause the sender until the block drains
  task automatic test_random(input int unsigned tx_pct, input int unsigned rx_pct,
                             input int hold_at, input int pause_at);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == hold_at) hold_cycles = HOLD_OFF;
      if (i == pause_at) wait_for_results();
      send_random_word();
    end
    wait_for_results();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value before reset
    req_if.valid      = 1'b0;
    req_if.operation  = OP_TICK;
    req_if.reg_offset = REG_MODE;
    req_if.write_data = '0;
    rst_n             = 1'b0;
    tx_idle_pct       = 0;
    rx_idle_pct       = 0;
    hold_cycles       = 0;
    mismatches        = 0;
    words_sent        = 0;
    ticks_sent        = 0;
    writes_sent       = 0;
    reads_sent        = 0;
    unused_sent       = 0;
    words_checked     = 0;
    alarms_seen       = 0;
    reset_watchdog_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words with random stalls on both sides
    tx_idle_pct = 28;
    rx_idle_pct = 28;
    test_reset_values();
    test_key_checks();
    test_restart();
    test_unused_op();
    wait_for_results();

    // Long tick runs at full rate
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_prescaler();

    // Random words: slow receiver, then slow sender, then no idling
    test_random(28, 81, 200, -1);
    test_random(81, 28, -1, 300);
    test_random(0, 0, 400, 100);

    wait_for_results();
    repeat (4) @(posedge clk);
    $display("Ran %0d request words: %0d ticks, %0d writes, %0d reads, %0d unused ops.",
             words_sent, ticks_sent, writes_sent, reads_sent, unused_sent);
    $display("Checked %0d status words, %0d with a reset or interrupt request raised.",
             words_checked, alarms_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/kwt_pkg.sv
rtl/kwt_if.sv
rtl/keyed_watchdog_timer.sv
bench/testbench.sv
